FILE: rtl/sfr_pkg.sv
// sensor frame receiver package: frame constants, sequencer state type and
// the helper that picks the buffer positions of the two words to extract
// no dependencies
package sfr_pkg;

  localparam int unsigned FRAME_LEN  = 9;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned WORD_W     = 16;
  localparam int unsigned FRAME_AW   = $clog2(FRAME_LEN);
  localparam int unsigned COUNT_W    = $clog2(FRAME_LEN + 1);
  localparam int unsigned WORD_BYTES = 4;
  localparam int unsigned WIDX_W     = $clog2(WORD_BYTES);

  localparam logic [BYTE_W-1:0]   HEADER_BYTE = 8'hFF;
  localparam logic [FRAME_AW-1:0] POS_HEADER  = FRAME_AW'(0);
  localparam logic [FRAME_AW-1:0] POS_CHECK   = FRAME_AW'(FRAME_LEN - 1);
  localparam logic [COUNT_W-1:0]  CNT_LAST    = COUNT_W'(FRAME_LEN - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HDR,
    ST_READ,
    ST_LOAD
  } sfr_state_t;

  // buffer position of the n-th value byte, big endian, by frame layout
  // question-answer: bytes 2,3 then 6,7; active upload: bytes 4,5 then 6,7
  function automatic logic [FRAME_AW-1:0] value_pos(input logic qa_mode,
                                                    input logic [WIDX_W-1:0] idx);
    logic [FRAME_AW-1:0] pos;
    begin
      pos = FRAME_AW'(4) + FRAME_AW'(idx);
      if (qa_mode && !idx[WIDX_W-1]) begin
        pos = FRAME_AW'(2) + FRAME_AW'(idx);
      end
      return pos;
    end
  endfunction

endpackage

FILE: rtl/sensor_frame_receiver.sv
// sensor_frame_receiver: serial byte stream to checked sensor readings.
// Each received byte transfer is stored in a 9-entry frame buffer ram
// (sfr_ram); a byte that does not complete a frame leaves the input ready for
// the next byte. The ninth byte starts a short sequence over the ram's single
// read port: read back the header byte, then, on a good header and checksum,
// read the four value bytes and load the result, after any wait for the
// previous result to be taken. The input is closed while this sequence runs.
// The checksum is summed on the fly as bytes 1 to 7 arrive. A frame with a
// bad header is resynchronised on the next 0xFF byte. The result register
// holds the three readings; the input stays open while a result waits, until
// a further frame has to load its result.
// depends on sfr_pkg and sfr_ram
module sensor_frame_receiver
  import sfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data,
  // received bytes
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_rx_byte,
  // readings
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] out_concentration_ppb,
  output logic [WORD_W-1:0] out_concentration_ug,
  output logic [WORD_W-1:0] out_full_scale_max
);

  sfr_state_t state_r, state_nxt;

  logic                  qa_mode_r;
  logic [COUNT_W-1:0]    count_r, count_nxt;
  logic [BYTE_W-1:0]     sum_r, sum_nxt;
  logic                  chk_ok_r, chk_ok_nxt;
  logic [BYTE_W-1:0]     last_r, last_nxt;
  logic [WIDX_W-1:0]     idx_r, idx_nxt;
  logic [4*BYTE_W-1:0]   collect_r, collect_nxt;
  logic [WORD_W-1:0]     ppb_r, ppb_nxt;
  logic [WORD_W-1:0]     ug_r, ug_nxt;
  logic [WORD_W-1:0]     max_r, max_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic                  ram_wr_en;
  logic [FRAME_AW-1:0]   ram_wr_addr;
  logic [BYTE_W-1:0]     ram_wr_data;
  logic [FRAME_AW-1:0]   ram_rd_addr;
  logic [BYTE_W-1:0]     ram_rd_data;

  logic                  in_fire;
  logic [FRAME_AW-1:0]   wr_pos;
  logic [WORD_W-1:0]     word_a;
  logic [WORD_W-1:0]     word_b;

  // frame buffer
  sfr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (FRAME_LEN)
  ) u_frame_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qa_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      qa_mode_r <= cfg_data;
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign wr_pos   = count_r[FRAME_AW-1:0];
  assign word_a   = collect_r[4*BYTE_W-1:2*BYTE_W];
  assign word_b   = collect_r[2*BYTE_W-1:0];

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      ppb_r       <= '0;
      ug_r        <= '0;
      max_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      ppb_r       <= ppb_nxt;
      ug_r        <= ug_nxt;
      max_r       <= max_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    sum_r     <= sum_nxt;
    chk_ok_r  <= chk_ok_nxt;
    last_r    <= last_nxt;
    idx_r     <= idx_nxt;
    collect_r <= collect_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    chk_ok_nxt    = chk_ok_r;
    last_nxt      = last_r;
    idx_nxt       = idx_r;
    collect_nxt   = collect_r;
    ppb_nxt       = ppb_r;
    ug_nxt        = ug_r;
    max_nxt       = max_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = wr_pos;
    ram_wr_data   = in_rx_byte;
    ram_rd_addr   = POS_HEADER;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          ram_wr_en = 1'b1;
          if (wr_pos == POS_CHECK) begin
            // frame complete: test checksum now, read back the header
            chk_ok_nxt = (BYTE_W'(8'd0 - sum_r) == in_rx_byte);
            last_nxt   = in_rx_byte;
            state_nxt  = ST_HDR;
          end else begin
            count_nxt = count_r + COUNT_W'(1);
            if (wr_pos == POS_HEADER) begin
              sum_nxt = '0;
            end else begin
              sum_nxt = sum_r + in_rx_byte;
            end
          end
        end
      end

      ST_HDR: begin
        if (ram_rd_data == HEADER_BYTE) begin
          count_nxt = '0;
          if (chk_ok_r) begin
            ram_rd_addr = value_pos(qa_mode_r, '0);
            idx_nxt     = '0;
            state_nxt   = ST_READ;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else if (last_r == HEADER_BYTE) begin
          // resynchronise: the last byte opens a new frame
          ram_wr_en   = 1'b1;
          ram_wr_addr = POS_HEADER;
          ram_wr_data = HEADER_BYTE;
          count_nxt   = COUNT_W'(1);
          sum_nxt     = '0;
          state_nxt   = ST_IDLE;
        end else begin
          count_nxt = CNT_LAST;
          state_nxt = ST_IDLE;
        end
      end

      ST_READ: begin
        // gather value bytes, most significant first
        collect_nxt = {collect_r[3*BYTE_W-1:0], ram_rd_data};
        if (idx_r == WIDX_W'(WORD_BYTES - 1)) begin
          state_nxt = ST_LOAD;
        end else begin
          ram_rd_addr = value_pos(qa_mode_r, idx_r + WIDX_W'(1));
          idx_nxt     = idx_r + WIDX_W'(1);
        end
      end

      ST_LOAD: begin
        // update held readings once the result register is free
        if (!out_valid_r || out_ready) begin
          if (qa_mode_r) begin
            ug_nxt  = word_a;
            ppb_nxt = word_b;
          end else begin
            ppb_nxt = word_a;
            max_nxt = word_b;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // result port: held readings stay put while a result waits
  assign out_valid             = out_valid_r;
  assign out_concentration_ppb = ppb_r;
  assign out_concentration_ug  = ug_r;
  assign out_full_scale_max    = max_r;

endmodule

FILE: rtl/sfr_ram.sv
// generic single-clock ram, one write port and one read port, registered read
// no dependencies
module sfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 9,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, old data on a same-address collision
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: dv/tb_sensor_frame_receiver.sv
// testbench for sensor_frame_receiver: directed byte table, then random
// frames and noise, checked against the table or a predictor of the frame parser
// depends on sfr_pkg and the sensor_frame_receiver rtl
module tb_sensor_frame_receiver
  import sfr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 100_000;
  localparam int SETTLE_CYCLES = 12;
  localparam int TAIL_CYCLES  = 20;
  localparam int HOLD_AT      = 8;
  localparam int HOLD_CYCLES  = 400;
  localparam int N_DIRECTED   = 30;

  localparam logic LAYOUT_ACTIVE = 1'b0;
  localparam logic LAYOUT_QA     = 1'b1;

  typedef struct packed {
    logic [WORD_W-1:0] ppb;
    logic [WORD_W-1:0] ug;
    logic [WORD_W-1:0] fsmax;
  } reading_t;

  typedef enum logic [1:0] {
    CHK_PREDICT,
    CHK_SILENT,
    CHK_TYPED
  } row_check_t;

  typedef enum logic [1:0] {
    ROW_BYTE,
    ROW_LAYOUT
  } row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [BYTE_W-1:0] data;
    row_check_t        chk;
    reading_t          want;
  } row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_data = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] in_rx_byte = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [WORD_W-1:0] out_concentration_ppb;
  logic [WORD_W-1:0] out_concentration_ug;
  logic [WORD_W-1:0] out_full_scale_max;

  // how the byte on the input is to be checked, held with the payload
  row_check_t row_check = CHK_PREDICT;
  reading_t   row_want = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int results_taken = 0;
  int stall_left = 0;
  bit hold_done = 1'b0;
  int cycle_count = 0;
  int fail_count = 0;

  reading_t expected_readings [$];

  // predictor state
  logic [BYTE_W-1:0] frame_buf [FRAME_LEN];
  int                fill_count = 0;
  logic [WORD_W-1:0] hold_ppb = '0;
  logic [WORD_W-1:0] hold_ug = '0;
  logic [WORD_W-1:0] hold_max = '0;
  logic              qa_layout = LAYOUT_ACTIVE;

  // bad header, resync, mode change mid-frame, checksum mismatch
  row_t directed_rows [N_DIRECTED] = '{
    '{ROW_BYTE,   8'h00, CHK_PREDICT, '0},
    '{ROW_BYTE,   8'h80, CHK_PREDICT, '0},
    '{ROW_BYTE,   8'h7F, CHK_PREDICT, '0},
    '{ROW_BYTE,   8'h01, CHK_PREDICT, '0},
    '{ROW_BYTE,   8'hFE, CHK_PREDICT, '0},
    '{ROW_BYTE,   8'h40, CHK_PREDICT, '0},
    '{ROW_BYTE,   8'h02, CHK_PREDICT, '0},
    '{ROW_BYTE,   8'h20, CHK_PREDICT, '0},
    '{ROW_BYTE,   8'h5A, CHK_SILENT,  '0},
    '{ROW_BYTE,   8'hC3, CHK_SILENT,  '0},
    '{ROW_BYTE,   8'hFF, CHK_SILENT,  '0},
    '{ROW_BYTE,   8'hFF, CHK_PREDICT, '0},
    '{ROW_BYTE,   8'hFF, CHK_PREDICT, '0},
    '{ROW_BYTE,   8'hFF, CHK_PREDICT, '0},
    '{ROW_LAYOUT, 8'(LAYOUT_QA), CHK_PREDICT, '0},
    '{ROW_BYTE,   8'hFF, CHK_PREDICT, '0},
    '{ROW_BYTE,   8'hFF, CHK_PREDICT, '0},
    '{ROW_BYTE,   8'hFF, CHK_PREDICT, '0},
    '{ROW_BYTE,   8'hFF, CHK_PREDICT, '0},
    '{ROW_BYTE,   8'h07, CHK_TYPED,   '{16'hFFFF, 16'hFFFF, 16'h0000}},
    '{ROW_LAYOUT, 8'(LAYOUT_ACTIVE), CHK_PREDICT, '0},
    '{ROW_BYTE,   8'hFF, CHK_PREDICT, '0},
    '{ROW_BYTE,   8'h00, CHK_PREDICT, '0},
    '{ROW_BYTE,   8'h00, CHK_PREDICT, '0},
    '{ROW_BYTE,   8'h00, CHK_PREDICT, '0},
    '{ROW_BYTE,   8'h00, CHK_PREDICT, '0},
    '{ROW_BYTE,   8'h00, CHK_PREDICT, '0},
    '{ROW_BYTE,   8'h00, CHK_PREDICT, '0},
    '{ROW_BYTE,   8'h00, CHK_PREDICT, '0},
    '{ROW_BYTE,   8'h01, CHK_SILENT,  '0}
  };

  sensor_frame_receiver i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_data              (cfg_data),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_rx_byte            (in_rx_byte),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_concentration_ppb (out_concentration_ppb),
    .out_concentration_ug  (out_concentration_ug),
    .out_full_scale_max    (out_full_scale_max)
  );

  always #5 clk = ~clk;

  // store one byte, return 1 with the new readings when a frame checks out
  function automatic bit frame_step(input logic [BYTE_W-1:0] b, output reading_t r);
    logic [BYTE_W-1:0] sum;
    r = '0;
    if (fill_count >= FRAME_LEN) fill_count = FRAME_LEN - 1;
    frame_buf[fill_count] = b;
    fill_count++;
    if (fill_count < FRAME_LEN) return 1'b0;
    if (frame_buf[POS_HEADER] == HEADER_BYTE) begin
      fill_count = 0;
      sum = '0;
      for (int k = 1; k < FRAME_LEN - 1; k++) sum += frame_buf[k];
      sum = -sum;
      if (sum != frame_buf[POS_CHECK]) return 1'b0;
      // big endian words: ug 2-3 and ppb 6-7, or ppb 4-5 and maximum 6-7
      if (qa_layout == LAYOUT_QA) begin
        hold_ug  = {frame_buf[2], frame_buf[3]};
        hold_ppb = {frame_buf[6], frame_buf[7]};
      end else begin
        hold_ppb = {frame_buf[4], frame_buf[5]};
        hold_max = {frame_buf[6], frame_buf[7]};
      end
      r = '{hold_ppb, hold_ug, hold_max};
      return 1'b1;
    end
    // bad header: resync on 0xff, otherwise keep overwriting the last slot
    if (b == HEADER_BYTE) begin
      frame_buf[POS_HEADER] = b;
      fill_count = 1;
    end else begin
      fill_count = FRAME_LEN - 1;
    end
    return 1'b0;
  endfunction

  task automatic check_field(input string what, input logic [WORD_W-1:0] want,
                             input logic [WORD_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, what, want, got);
      fail_count++;
    end
  endtask

  // predict on input transfers, check on output transfers
  always @(posedge clk) begin
    reading_t next_r;
    reading_t want_r;
    bit       produced;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) qa_layout = cfg_data;
      if (in_valid && in_ready) begin
        produced = frame_step(in_rx_byte, next_r);
        case (row_check)
          CHK_PREDICT: if (produced) expected_readings.push_back(next_r);
          CHK_TYPED:   expected_readings.push_back(row_want);
          default:     ;
        endcase
      end
      if (out_valid && out_ready) begin
        results_taken <= results_taken + 1;
        if (expected_readings.size() == 0) begin
          $display("%0t: reading %h %h %h with none expected", $time,
                   out_concentration_ppb, out_concentration_ug, out_full_scale_max);
          fail_count++;
        end else begin
          want_r = expected_readings.pop_front();
          check_field("ppb", want_r.ppb, out_concentration_ppb);
          check_field("ug", want_r.ug, out_concentration_ug);
          check_field("full scale", want_r.fsmax, out_full_scale_max);
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold-off to back up the input
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!hold_done && results_taken == HOLD_AT) begin
      out_ready  <= 1'b0;
      stall_left <= HOLD_CYCLES;
      hold_done  <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // one byte transfer, with a random gap in front
  task automatic send_byte(input logic [BYTE_W-1:0] b, input row_check_t chk,
                           input reading_t want);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    row_check  <= chk;
    row_want   <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_readings();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_readings.size() != 0);
  endtask

  // layout change only once the block has gone quiet
  task automatic set_layout(input logic layout);
    drain_readings();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= layout;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // biased towards the all-zero and all-one byte values
  function automatic logic [BYTE_W-1:0] pick_byte();
    int sel;
    sel = $urandom_range(99);
    if (sel < 15) return '0;
    if (sel < 30) return '1;
    return BYTE_W'($urandom_range(255));
  endfunction

  // mostly well-formed frames, some with a corrupt checksum, plus noise bursts
  task automatic send_random_stream(input int total);
    logic [BYTE_W-1:0] fr [FRAME_LEN];
    logic [BYTE_W-1:0] sum;
    int                sent;
    sent = 0;
    while (sent < total) begin
      if ($urandom_range(99) < 80) begin
        fr[POS_HEADER] = HEADER_BYTE;
        sum = '0;
        for (int k = 1; k < FRAME_LEN - 1; k++) begin
          fr[k] = pick_byte();
          sum  += fr[k];
        end
        fr[POS_CHECK] = -sum;
        if ($urandom_range(99) < 15) fr[POS_CHECK] ^= BYTE_W'($urandom_range(255, 1));
        foreach (fr[j]) send_byte(fr[j], CHK_PREDICT, '0);
        sent += FRAME_LEN;
      end else begin
        repeat ($urandom_range(10, 1)) begin
          send_byte(pick_byte(), CHK_PREDICT, '0);
          sent++;
        end
      end
    end
  endtask

  initial begin
    foreach (frame_buf[k]) frame_buf[k] = '0;
    repeat (8) @(posedge clk);
    rst_n         <= 1'b1;
    send_idle_pct <= 15;
    recv_idle_pct <= 50;

    // directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_LAYOUT) begin
        set_layout(directed_rows[i].data[0]);
      end else begin
        send_byte(directed_rows[i].data, directed_rows[i].chk, directed_rows[i].want);
      end
    end

    // active upload, sender rarely idle, receiver often stalls
    send_random_stream(190);

    // question-answer, roles swapped, one full pause halfway
    set_layout(LAYOUT_QA);
    send_idle_pct <= 50;
    recv_idle_pct <= 15;
    send_random_stream(95);
    drain_readings();
    send_random_stream(95);

    // active upload at full rate, then question-answer at full rate
    set_layout(LAYOUT_ACTIVE);
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    send_random_stream(100);
    set_layout(LAYOUT_QA);
    send_random_stream(100);

    drain_readings();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/sfr_pkg.sv
rtl/sfr_ram.sv
rtl/sensor_frame_receiver.sv
dv/tb_sensor_frame_receiver.sv
